### sv/assert_macros.svh
// assertion macros shared by the pixel blit modules
// depends on a clk and an active low rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk, off while in reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every rising edge of clk, also during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/cpbp_pkg.sv
// shared types, register codes and the channel packing function
// for the clipped pixel blit pack block; depends on nothing
package cpbp_pkg;

    localparam int SOURCE_DIM_MAX_DEF = 4096;
    localparam int QUEUE_DEPTH_DEF    = 2;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_WIDE_PIXELS   = 3'd0,
        REG_RED_LAYOUT    = 3'd1,
        REG_GREEN_LAYOUT  = 3'd2,
        REG_BLUE_LAYOUT   = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5,
        REG_LINE_PITCH    = 3'd6,
        REG_PAN_BASE      = 3'd7
    } reg_index_t;

    // configuration bundle seen by front and back
    typedef struct packed {
        logic        wide_pixels;
        logic [8:0]  red_layout;
        logic [8:0]  green_layout;
        logic [8:0]  blue_layout;
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [14:0] line_pitch;
        logic [27:0] pan_base;
    } cfg_t;

    // classified pixel handed from front to back
    typedef struct packed {
        logic        draw;
        logic [12:0] sx;
        logic [12:0] sy;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } item_t;

    // place one color channel at its field offset
    function automatic logic [31:0] place_channel(
        input logic [7:0] chan,
        input logic [8:0] layout,
        input logic       wide
    );
        logic [3:0] len;
        logic [4:0] off;
        logic [7:0] v;
        len = layout[3:0];
        off = layout[8:4];
        v   = chan;
        if (!wide)
        begin
            if (len > 4'd8)
            begin
                len = 4'd8;
            end
            v = (len == 4'd0) ? 8'd0 : (chan >> (4'd8 - len));
        end
        return {24'd0, v} << off;
    endfunction

endpackage

### sv/cpbp_front.sv
// front stage: accepts pixel beats, computes screen position and clip flag
// depends on cpbp_pkg
module cpbp_front
    import cpbp_pkg::*;
#(
    parameter int SOURCE_DIM_MAX = SOURCE_DIM_MAX_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic [7:0]         alpha,
    input  logic signed [13:0] dest_x,
    input  logic signed [13:0] dest_y,
    input  logic [11:0]        column,
    input  logic [11:0]        row,
    output logic               push_valid,
    input  logic               push_ready,
    output item_t              push_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  [14:0] sx;
    logic  [14:0] sy;
    logic  col_ok;
    logic  row_ok;
    logic  x_ok;
    logic  y_ok;
    logic  accept;
    item_t item_next;

    // screen position, 15 bits hold every sum without overflow
    assign sx = {dest_x[13], dest_x} + {3'd0, column};
    assign sy = {dest_y[13], dest_y} + {3'd0, row};

    // clipping against source size and screen size
    assign col_ok = ({20'd0, column} < 32'(SOURCE_DIM_MAX));
    assign row_ok = ({20'd0, row} < 32'(SOURCE_DIM_MAX));
    assign x_ok   = !sx[14] && (sx[13:0] < {1'b0, cfg.screen_width});
    assign y_ok   = !sy[14] && (sy[13:0] < {1'b0, cfg.screen_height});

    always_comb
    begin
        item_next.draw  = (alpha != 8'd0) && col_ok && row_ok && x_ok && y_ok;
        item_next.sx    = sx[12:0];
        item_next.sy    = sy[12:0];
        item_next.red   = red;
        item_next.green = green;
        item_next.blue  = blue;
    end

    // one holding register, refilled in the cycle it drains
    assign in_ready   = !valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

### sv/cpbp_queue.sv
// short queue of classified pixels between front and back
// depends on cpbp_pkg and assert_macros.svh
`include "assert_macros.svh"
module cpbp_queue
    import cpbp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t          slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // fill count never passes the depth
    `ASSERT_CLK(a_count_bound, count_reg <= CW'(DEPTH), "queue count above depth")
    // a push without a pop raises the count by one
    `ASSERT_CLK(a_count_step, (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1), "queue count did not grow on push")

endmodule

### sv/cpbp_back.sv
// back stages: packs the pixel word and forms the byte address
// depends on cpbp_pkg and assert_macros.svh
`include "assert_macros.svh"
module cpbp_back
    import cpbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  item_t       pop_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        write_enable,
    output logic [29:0] byte_address,
    output logic [31:0] pixel_word
);

    logic        advance;
    logic        s1_valid_reg;
    logic        s1_draw_reg;
    logic [14:0] s1_xoff_reg;
    logic [27:0] s1_yprod_reg;
    logic [31:0] s1_word_reg;
    logic        s2_valid_reg;
    logic        s2_draw_reg;
    logic [29:0] s2_addr_reg;
    logic [31:0] s2_word_reg;
    logic [14:0] xoff_next;
    logic [27:0] yprod_next;
    logic [31:0] word_next;
    logic [29:0] addr_next;

    // whole pipe moves together while the output is free
    assign advance   = !s2_valid_reg || out_ready;
    assign pop_ready = advance;

    // stage 1: column offset, row product, channel packing
    assign xoff_next  = cfg.wide_pixels ? {pop_item.sx, 2'b00} : {1'b0, pop_item.sx, 1'b0};
    assign yprod_next = pop_item.sy * cfg.line_pitch;

    always_comb
    begin
        word_next = place_channel(pop_item.red, cfg.red_layout, cfg.wide_pixels)
                  | place_channel(pop_item.green, cfg.green_layout, cfg.wide_pixels)
                  | place_channel(pop_item.blue, cfg.blue_layout, cfg.wide_pixels);
        if (!cfg.wide_pixels)
        begin
            word_next[31:16] = 16'd0;
        end
    end

    // stage 2: address sum, 30 bits hold every sum without overflow
    assign addr_next = {2'b00, cfg.pan_base} + {15'd0, s1_xoff_reg} + {2'b00, s1_yprod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= pop_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_draw_reg  <= pop_item.draw;
            s1_xoff_reg  <= xoff_next;
            s1_yprod_reg <= yprod_next;
            s1_word_reg  <= word_next;
            s2_draw_reg  <= s1_draw_reg;
            s2_addr_reg  <= s1_draw_reg ? addr_next : 30'd0;
            s2_word_reg  <= s1_draw_reg ? s1_word_reg : 32'd0;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign write_enable = s2_draw_reg;
    assign byte_address = s2_addr_reg;
    assign pixel_word   = s2_word_reg;

    // a skipped pixel carries a zero address and word
    `ASSERT_CLK(a_skip_zero, (out_valid && !write_enable) |-> (byte_address == 30'd0 && pixel_word == 32'd0), "skipped pixel with nonzero payload")
    // a stalled first stage keeps its beat
    `ASSERT_CLK(a_s1_hold, (s1_valid_reg && !advance) |=> s1_valid_reg, "stage 1 beat lost on stall")

endmodule

### sv/clipped_pixel_blit_pack.sv
// top level of the clipped pixel blit pack block: config registers,
// front classifier, queue and back packer; depends on cpbp_pkg and its submodules
//
//   channel  direction  handshake            payload
//   in       in         in_valid/in_ready    red green blue alpha dest_x dest_y column row
//   out      out        out_valid/out_ready  write_enable byte_address pixel_word
//   cfg      in         cfg_write            cfg_index cfg_data
//
// one pixel per clock sustained while out_ready holds; from input beat to result a pixel
// passes the front register, queue slot, pack/multiply stage and address adder stage
// the 13x15 row-times-pitch multiplier shares its stage with the channel packing
// reset clears all valid flags and config registers to zero
// the front and the back stall independently, the queue (two entries by default) absorbs the slack
module clipped_pixel_blit_pack
    import cpbp_pkg::*;
#(
    parameter int SOURCE_DIM_MAX = SOURCE_DIM_MAX_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [27:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic [7:0]         alpha,
    input  logic signed [13:0] dest_x,
    input  logic signed [13:0] dest_y,
    input  logic [11:0]        column,
    input  logic [11:0]        row,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               write_enable,
    output logic [29:0]        byte_address,
    output logic [31:0]        pixel_word
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    // config register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_WIDE_PIXELS:   cfg_next.wide_pixels   = cfg_data[0];
                REG_RED_LAYOUT:    cfg_next.red_layout    = cfg_data[8:0];
                REG_GREEN_LAYOUT:  cfg_next.green_layout  = cfg_data[8:0];
                REG_BLUE_LAYOUT:   cfg_next.blue_layout   = cfg_data[8:0];
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[12:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data[12:0];
                REG_LINE_PITCH:    cfg_next.line_pitch    = cfg_data[14:0];
                REG_PAN_BASE:      cfg_next.pan_base      = cfg_data[27:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front classifier
    cpbp_front #(
        .SOURCE_DIM_MAX (SOURCE_DIM_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .dest_x     (dest_x),
        .dest_y     (dest_y),
        .column     (column),
        .row        (row),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // queue between the two halves
    cpbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // back packer
    cpbp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .write_enable (write_enable),
        .byte_address (byte_address),
        .pixel_word   (pixel_word)
    );

endmodule
